@@ hw/rtl/hfc_pkg.sv @@
// Shared types, codes and a helper function for the header and footer file carver.
package hfc_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int PAT_W     = 64;
    localparam int FNUM_W    = 16;
    localparam int OUT_TDATA = 32;

    localparam logic EVT_START = 1'b0;
    localparam logic EVT_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        CFG_HDR_PAT = 2'd0,
        CFG_HDR_LEN = 2'd1,
        CFG_FTR_PAT = 2'd2,
        CFG_FTR_LEN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_cell_link;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] l;
        l = len;
        if (l == '0) begin
            l = LEN_W'(1);
        end
        if (l > max_len) begin
            l = max_len;
        end
        return l;
    endfunction

endpackage

@@ hw/rtl/hfc_cell.sv @@
// One byte cell of the signature window: holds a byte, passes it on and compares it.
module hfc_cell
    import hfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  t_cell_link        i_prev,
    input  logic [BYTE_W-1:0] i_pat,
    input  logic              i_en,
    output t_cell_link        o_link,
    output logic              o_hit
);

    t_cell_link r_link;
    t_cell_link n_link;
    t_cell_link w_look;

    always_comb begin
        w_look = i_ctl.shift ? i_prev : r_link;
        o_hit  = !i_en || (w_look.valid && (w_look.data == i_pat));
    end

    always_comb begin
        if (i_ctl.clear) begin
            n_link = '0;
        end else if (i_ctl.shift) begin
            n_link = i_prev;
        end else begin
            n_link = r_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

@@ hw/rtl/header_footer_file_carver.sv @@
// Top level of the header and footer file carver: a chain of byte cells and the carve control.
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle if unstalled; the window compare across the cell row sets this.
// The slave side keeps accepting while the output register is taken in the same cycle.
// Synchronous active-low reset empties the window, stops any carve, zeroes the file counter
// and loads the signature registers with patterns of zero and lengths of one.
module header_footer_file_carver
    import hfc_pkg::*;
#(
    parameter int MAX_SIGNATURE_BYTES = 8,
    parameter int COUNTER_BITS        = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // data_byte
    input  logic                 s_axis_tlast,   // stream_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_TDATA-1:0] m_axis_tdata,   // carved_byte, file_number, truncated, zeros
    output logic                 m_axis_tuser,   // event_kind
    output logic                 m_axis_tlast,   // carve_end
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data
);

    logic [PAT_W-1:0] r_hdr_pat;
    logic [LEN_W-1:0] r_hdr_len;
    logic [PAT_W-1:0] r_ftr_pat;
    logic [LEN_W-1:0] r_ftr_len;

    logic                    r_carving;
    logic                    n_carving;
    logic [COUNTER_BITS-1:0] r_file_cnt;
    logic [COUNTER_BITS-1:0] n_file_cnt;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic [FNUM_W-1:0] r_out_fnum;
    logic              r_out_end;
    logic              r_out_trunc;

    logic              w_fire;
    logic              w_emit;
    logic              w_match;
    logic [PAT_W-1:0]  w_pat;
    logic [LEN_W-1:0]  w_eff;
    logic [31:0]       w_cnt_ext;
    logic [FNUM_W-1:0] w_fnum;
    t_cell_ctl         w_ctl;

    t_cell_link                     w_link [MAX_SIGNATURE_BYTES];
    logic [MAX_SIGNATURE_BYTES-1:0] w_hit;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pat <= '0;
            r_hdr_len <= LEN_W'(1);
            r_ftr_pat <= '0;
            r_ftr_len <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HDR_PAT: r_hdr_pat <= i_cfg_data;
                CFG_HDR_LEN: r_hdr_len <= i_cfg_data[LEN_W-1:0];
                CFG_FTR_PAT: r_ftr_pat <= i_cfg_data;
                CFG_FTR_LEN: r_ftr_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Only one window is ever live, so the footer search reuses the header cells.
    assign w_pat = r_carving ? r_ftr_pat : r_hdr_pat;
    assign w_eff = eff_len(r_carving ? r_ftr_len : r_hdr_len, LEN_W'(MAX_SIGNATURE_BYTES));

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SIGNATURE_BYTES; gi++) begin : g_cell
            t_cell_link w_prev;
            if (gi == 0) begin : g_head
                assign w_prev = '{valid: 1'b1, data: s_axis_tdata};
            end else begin : g_body
                assign w_prev = w_link[gi-1];
            end
            hfc_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_prev (w_prev),
                .i_pat  (w_pat[gi*BYTE_W +: BYTE_W]),
                .i_en   (LEN_W'(gi) < w_eff),
                .o_link (w_link[gi]),
                .o_hit  (w_hit[gi])
            );
        end
    endgenerate

    assign w_match = &w_hit;

    always_comb begin
        w_ctl.shift = w_fire;
        w_ctl.clear = w_fire && (s_axis_tlast || w_match);
        w_emit      = w_fire && (r_carving || w_match);
        n_carving   = r_carving;
        n_file_cnt  = r_file_cnt;
        if (w_fire) begin
            if (r_carving) begin
                n_carving = !(w_match || s_axis_tlast);
            end else begin
                n_carving = w_match && !s_axis_tlast;
                if (w_match && (r_file_cnt != '1)) begin
                    n_file_cnt = r_file_cnt + COUNTER_BITS'(1);
                end
            end
        end
        w_cnt_ext = 32'(n_file_cnt);
        w_fnum    = (w_cnt_ext > 32'h0000_FFFF) ? '1 : w_cnt_ext[FNUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carving  <= 1'b0;
            r_file_cnt <= '0;
        end else begin
            r_carving  <= n_carving;
            r_file_cnt <= n_file_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind  <= r_carving ? EVT_BYTE : EVT_START;
            r_out_byte  <= r_carving ? s_axis_tdata : '0;
            r_out_fnum  <= w_fnum;
            r_out_end   <= r_carving && w_match;
            r_out_trunc <= s_axis_tlast && !(r_carving && w_match);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_end;
    assign m_axis_tdata  = {{(OUT_TDATA - BYTE_W - FNUM_W - 1){1'b0}},
                            r_out_trunc, r_out_fnum, r_out_byte};

    a_start_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == EVT_START) |-> !r_out_end)
        else $error("start event flagged as carve end");

    a_end_not_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_end && r_out_trunc))
        else $error("carve end and truncation both set");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && s_axis_tlast |=> !r_carving)
        else $error("carve still open after stream end");

    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_file_cnt >= $past(r_file_cnt))
        else $error("file counter went backwards");

endmodule
